FILE: hdl/nearest_palette_color_mapper_assert.svh
// assertion macros for the nearest palette color mapper
// included by the top level, no other dependencies
`ifndef NEAREST_PALETTE_COLOR_MAPPER_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_MAPPER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define NPCM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define NPCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/npcm_pkg.sv
// shared types and constants for the nearest palette color mapper
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package npcm_pkg;

    localparam int DEFAULT_PALETTE_DEPTH = 256;
    localparam int CHAN_W    = 8;
    localparam int COLOR_W   = 3 * CHAN_W;
    localparam int INDEX_W   = 8;
    localparam int CFG_W     = 9;
    localparam int DIST_W    = 18;
    localparam int SQ_W      = 2 * CHAN_W;
    localparam int IDX_EXT_W = 13;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 56;
    localparam int M_FIELD_W = 3 * CHAN_W + INDEX_W + DIST_W;

    localparam logic [CFG_W-1:0] ENTRIES_RESET = CFG_W'(1);

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_MAP  = 1'b1;

    typedef struct packed {
        logic start;
        logic rd_en;
        logic rd_last;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

FILE: hdl/npcm_ram.sv
// generic single-port-write ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module npcm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/npcm_ctrl.sv
// controller: accepts transactions, holds entries_in_use, sequences palette scan
// depends on npcm_pkg
`timescale 1ns / 1ps
`default_nettype none

module npcm_ctrl import npcm_pkg::*; #(
    parameter int PALETTE_DEPTH = DEFAULT_PALETTE_DEPTH,
    parameter int IDX_W         = $clog2(PALETTE_DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data,
    input  wire logic             s_tvalid,
    input  wire logic             s_mode,
    output logic                  s_tready,
    input  wire status_t          status,
    output cmd_t                  cmd,
    output logic      [IDX_W-1:0] rd_addr
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     addr_reg, addr_next;
    logic [IDX_W-1:0]     last_reg, last_next;
    logic [CFG_W-1:0]     entries_reg, entries_next;
    logic [IDX_EXT_W-1:0] cnt_raw, cnt;
    logic                 accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign rd_addr  = addr_reg;

    always_comb begin
        cnt_raw = IDX_EXT_W'(entries_reg);
        if (cnt_raw == '0) begin
            cnt = IDX_EXT_W'(1);
        end else if (cnt_raw > IDX_EXT_W'(PALETTE_DEPTH)) begin
            cnt = IDX_EXT_W'(PALETTE_DEPTH);
        end else begin
            cnt = cnt_raw;
        end
    end

    always_comb begin
        cmd.start   = accept && (s_mode == MODE_MAP);
        cmd.rd_en   = (state_reg == ST_SCAN);
        cmd.rd_last = (state_reg == ST_SCAN) && (addr_reg == last_reg);
        cmd.emit    = (state_reg == ST_EMIT) && status.out_free;
    end

    always_comb begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        last_next    = last_reg;
        entries_next = cfg_wr_en ? cfg_wr_data : entries_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.start) begin
                    addr_next  = '0;
                    last_next  = IDX_W'(cnt - IDX_EXT_W'(1));
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cmd.rd_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    addr_next = addr_reg + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                if (status.scan_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            entries_reg <= ENTRIES_RESET;
        end else begin
            state_reg   <= state_next;
            entries_reg <= entries_next;
        end
        addr_reg <= addr_next;
        last_reg <= last_next;
    end

endmodule

`default_nettype wire

FILE: hdl/npcm_datapath.sv
// datapath: distance pipeline, running best entry and output register
// depends on npcm_pkg
`timescale 1ns / 1ps
`default_nettype none

module npcm_datapath import npcm_pkg::*; #(
    parameter int PALETTE_DEPTH = DEFAULT_PALETTE_DEPTH,
    parameter int IDX_W         = $clog2(PALETTE_DEPTH)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cmd_t               cmd,
    input  wire logic [IDX_W-1:0]   rd_addr,
    input  wire logic [CHAN_W-1:0]  px_red,
    input  wire logic [CHAN_W-1:0]  px_green,
    input  wire logic [CHAN_W-1:0]  px_blue,
    input  wire logic [COLOR_W-1:0] rd_data,
    input  wire logic               m_tready,
    output logic                    m_tvalid,
    output logic      [CHAN_W-1:0]  out_red,
    output logic      [CHAN_W-1:0]  out_green,
    output logic      [CHAN_W-1:0]  out_blue,
    output logic      [INDEX_W-1:0] best_index,
    output logic      [DIST_W-1:0]  best_distance,
    output status_t                 status
);

    logic [CHAN_W-1:0]  px_r_reg, px_g_reg, px_b_reg;

    logic               a_valid_reg, a_last_reg;
    logic [IDX_W-1:0]   a_idx_reg;

    logic               b_valid_reg, b_last_reg;
    logic [IDX_W-1:0]   b_idx_reg;
    logic [COLOR_W-1:0] b_color_reg;
    logic [SQ_W-1:0]    b_sq_r_reg, b_sq_g_reg, b_sq_b_reg;

    logic [DIST_W-1:0]  best_d_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [COLOR_W-1:0] best_color_reg;
    logic               done_reg;

    logic               out_valid_reg;
    logic [CHAN_W-1:0]  out_r_reg, out_g_reg, out_b_reg;
    logic [INDEX_W-1:0] out_idx_reg;
    logic [DIST_W-1:0]  out_d_reg;

    logic [CHAN_W-1:0]  c_r, c_g, c_b;
    logic [CHAN_W-1:0]  dr, dg, db;
    logic [DIST_W-1:0]  cand_d;
    logic               take;

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign c_r = rd_data[3*CHAN_W-1:2*CHAN_W];
    assign c_g = rd_data[2*CHAN_W-1:CHAN_W];
    assign c_b = rd_data[CHAN_W-1:0];
    assign dr  = abs_diff(px_r_reg, c_r);
    assign dg  = abs_diff(px_g_reg, c_g);
    assign db  = abs_diff(px_b_reg, c_b);

    assign cand_d = DIST_W'(b_sq_r_reg) + DIST_W'(b_sq_g_reg) + DIST_W'(b_sq_b_reg);
    assign take   = b_valid_reg && ((b_idx_reg == '0) || (cand_d < best_d_reg));

    assign status.scan_done = done_reg;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid      = out_valid_reg;
    assign out_red       = out_r_reg;
    assign out_green     = out_g_reg;
    assign out_blue      = out_b_reg;
    assign best_index    = out_idx_reg;
    assign best_distance = out_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= cmd.rd_en;
            b_valid_reg <= a_valid_reg;
            done_reg    <= b_valid_reg && b_last_reg;
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end

        if (cmd.start) begin
            px_r_reg <= px_red;
            px_g_reg <= px_green;
            px_b_reg <= px_blue;
        end

        a_idx_reg  <= rd_addr;
        a_last_reg <= cmd.rd_last;

        b_idx_reg   <= a_idx_reg;
        b_last_reg  <= a_last_reg;
        b_color_reg <= rd_data;
        b_sq_r_reg  <= SQ_W'(dr) * SQ_W'(dr);
        b_sq_g_reg  <= SQ_W'(dg) * SQ_W'(dg);
        b_sq_b_reg  <= SQ_W'(db) * SQ_W'(db);

        if (take) begin
            best_d_reg     <= cand_d;
            best_idx_reg   <= b_idx_reg;
            best_color_reg <= b_color_reg;
        end

        if (cmd.emit) begin
            out_r_reg   <= best_color_reg[3*CHAN_W-1:2*CHAN_W];
            out_g_reg   <= best_color_reg[2*CHAN_W-1:CHAN_W];
            out_b_reg   <= best_color_reg[CHAN_W-1:0];
            out_idx_reg <= INDEX_W'(best_idx_reg);
            out_d_reg   <= best_d_reg;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/nearest_palette_color_mapper.sv
// a map is accepted in idle, then scans N entries (N = entries searched), drains and emits
// its result; the scan does one palette ram read per cycle, and no new map is taken before emit
// load transactions are taken one per cycle while idle and give no result
// a result waiting on m_tready does not block the next load or map acceptance
// reset: synchronous active low, clears control and sets entries_in_use to 1
// palette contents are undefined after reset until loaded, there is no clearing pass
`timescale 1ns / 1ps
`default_nettype none

`include "nearest_palette_color_mapper_assert.svh"

module nearest_palette_color_mapper import npcm_pkg::*; #(
    parameter int PALETTE_DEPTH = DEFAULT_PALETTE_DEPTH
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [CFG_W-1:0]    cfg_wr_data,  // entries_in_use
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,      // entry_index, red, green, blue
    input  wire logic                s_tuser,      // mode
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata       // out_red, out_green, out_blue,
                                                   // best_index, best_distance, zero pad
);

    localparam int IDX_W = $clog2(PALETTE_DEPTH);

    cmd_t                 cmd;
    status_t              status;
    logic [IDX_W-1:0]     rd_addr;
    logic [COLOR_W-1:0]   rd_data;
    logic [IDX_EXT_W-1:0] load_idx;
    logic                 wr_en;

    logic [INDEX_W-1:0]   in_index;
    logic [CHAN_W-1:0]    in_red, in_green, in_blue;
    logic [CHAN_W-1:0]    out_red, out_green, out_blue;
    logic [INDEX_W-1:0]   best_index;
    logic [DIST_W-1:0]    best_distance;

    assign in_index = s_tdata[INDEX_W-1:0];
    assign in_red   = s_tdata[INDEX_W+CHAN_W-1:INDEX_W];
    assign in_green = s_tdata[INDEX_W+2*CHAN_W-1:INDEX_W+CHAN_W];
    assign in_blue  = s_tdata[INDEX_W+3*CHAN_W-1:INDEX_W+2*CHAN_W];

    assign load_idx = IDX_EXT_W'(in_index);
    assign wr_en    = s_tvalid && s_tready && (s_tuser == MODE_LOAD)
                      && (load_idx < IDX_EXT_W'(PALETTE_DEPTH));

    assign m_tdata = {(M_DATA_W - M_FIELD_W)'(0), best_distance, best_index,
                      out_blue, out_green, out_red};

    npcm_ctrl #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .IDX_W         (IDX_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_mode      (s_tuser),
        .s_tready    (s_tready),
        .status      (status),
        .cmd         (cmd),
        .rd_addr     (rd_addr)
    );

    npcm_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (load_idx[IDX_W-1:0]),
        .wdata ({in_red, in_green, in_blue}),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    npcm_datapath #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .IDX_W         (IDX_W)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .rd_addr       (rd_addr),
        .px_red        (in_red),
        .px_green      (in_green),
        .px_blue       (in_blue),
        .rd_data       (rd_data),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .out_red       (out_red),
        .out_green     (out_green),
        .out_blue      (out_blue),
        .best_index    (best_index),
        .best_distance (best_distance),
        .status        (status)
    );

    `NPCM_ASSERT_SAME(a_no_load_during_scan, aclk, aresetn, wr_en, !cmd.rd_en, "load write during palette scan")
    `NPCM_ASSERT_SAME(a_emit_into_free_out, aclk, aresetn, cmd.emit, !m_tvalid || m_tready, "result overwrites unread transaction")
    `NPCM_ASSERT_NEXT(a_scan_follows_start, aclk, aresetn, cmd.start, cmd.rd_en && (rd_addr == '0), "scan did not start at entry zero")

endmodule

`default_nettype wire

FILE: bench/nearest_palette_color_mapper_test.sv
// self-checking bench for nearest_palette_color_mapper: palette loads and pixel maps
// run against an in-bench nearest-color search, bursty sender and stalling receiver
// depends on npcm_pkg and the nearest_palette_color_mapper rtl only
`timescale 1ns / 1ps

module nearest_palette_color_mapper_test;
    import npcm_pkg::*;

    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int SETTLE_CYCLES = 270;
    localparam int DEPTH         = DEFAULT_PALETTE_DEPTH;

    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic [INDEX_W-1:0] index;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  red;
    } pixel_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]    cfg_wr_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = MODE_LOAD;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    logic [COLOR_W-1:0]  palette_copy [DEPTH];
    logic [CFG_W-1:0]    entries_setting = ENTRIES_RESET;
    pixel_result_t       pending_results [$];

    int  cycle_count = 0;
    int  mismatch_count = 0;
    int  result_count = 0;
    int  map_count = 0;
    int  load_count = 0;
    int  setting_count = 0;
    int  burst_left = 0;
    bit  gaps_on = 1'b1;

    nearest_palette_color_mapper u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),  // entries_in_use
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),      // entry_index, red, green, blue
        .s_tuser     (s_tuser),      // mode
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)       // out_red, out_green, out_blue, best_index,
                                     // best_distance, zero pad
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("[nearest_palette_color_mapper] ERROR");
            $finish;
        end
    end

    function automatic int searched_entries(input logic [CFG_W-1:0] setting);
        if (setting == 0)
            return 1;
        if (setting > DEPTH)
            return DEPTH;
        return int'(setting);
    endfunction

    function automatic pixel_result_t nearest_entry(input logic [7:0] r, g, b);
        pixel_result_t best;
        int            lowest_sum;
        int            sq_sum;
        int            dr, dg, db;
        best = '0;
        lowest_sum = 32'h7fff_ffff;
        for (int i = 0; i < searched_entries(entries_setting); i++) begin
            dr = int'(r) - int'(palette_copy[i][23:16]);
            dg = int'(g) - int'(palette_copy[i][15:8]);
            db = int'(b) - int'(palette_copy[i][7:0]);
            sq_sum = dr * dr + dg * dg + db * db;
            if (sq_sum < lowest_sum) begin
                lowest_sum = sq_sum;
                best.red = palette_copy[i][23:16];
                best.green = palette_copy[i][15:8];
                best.blue = palette_copy[i][7:0];
                best.index = INDEX_W'(i);
                best.distance = DIST_W'(sq_sum);
            end
        end
        return best;
    endfunction

    function automatic logic [7:0] near_channel(input logic [7:0] c);
        int v;
        v = int'(c) + int'($urandom_range(0, 6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    // one transaction on the input channel, model updated on acceptance
    task automatic send_item(input logic mode, input logic [7:0] idx, r, g, b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = gaps_on ? $urandom_range(0, 8) : 0;
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {b, g, r, idx};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (mode == MODE_LOAD) begin
            palette_copy[idx] = {r, g, b};
            load_count++;
        end else begin
            pending_results.insert(pending_results.size(), nearest_entry(r, g, b));
            map_count++;
        end
    endtask

    task automatic load_entry(input logic [7:0] idx, r, g, b);
        send_item(MODE_LOAD, idx, r, g, b);
    endtask

    task automatic map_pixel(input logic [7:0] r, g, b);
        send_item(MODE_MAP, 8'($urandom), r, g, b);
    endtask

    task automatic set_entries(input logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        entries_setting = value;
        setting_count++;
        burst_left = 0;
    endtask

    // receiver: stall style follows bits 11:10 of cycle_count, style 0 never stalls
    always @(posedge aclk) begin
        pixel_result_t want;
        pixel_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[M_FIELD_W-1:0];
            result_count++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transaction %h at cycle %0d",
                             m_tdata, cycle_count);
            end else begin
                want = pending_results.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.index !== want.index ||
                    got.distance !== want.distance) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch at cycle %0d: expected rgb %h%h%h index %0d ",
                                  "distance %0d, got rgb %h%h%h index %0d distance %0d"},
                                 cycle_count, want.red, want.green, want.blue, want.index,
                                 want.distance, got.red, got.green, got.blue, got.index,
                                 got.distance);
                end
            end
        end
        case (cycle_count[11:10])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_tready <= (cycle_count[3:0] < 4'd5);
            default: m_tready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    task automatic test_reset_setting();
        load_entry(8'd0, 8'h12, 8'h34, 8'h56);
        map_pixel(8'h00, 8'h00, 8'h00);
        map_pixel(8'hff, 8'hff, 8'hff);
        map_pixel(8'h12, 8'h34, 8'h56);
    endtask

    task automatic test_fill_palette();
        for (int i = 0; i < DEPTH; i++)
            load_entry(8'(i), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic test_extremes_and_ties();
        set_entries(CFG_W'(DEPTH));
        load_entry(8'd0, 8'h00, 8'h00, 8'h00);
        load_entry(8'd255, 8'hff, 8'hff, 8'hff);
        load_entry(8'd10, 8'd100, 8'd100, 8'd100);
        load_entry(8'd11, 8'd102, 8'd100, 8'd100);
        load_entry(8'd40, 8'd7, 8'd200, 8'd7);
        load_entry(8'd41, 8'd7, 8'd200, 8'd7);
        map_pixel(8'h00, 8'h00, 8'h00);
        map_pixel(8'hff, 8'hff, 8'hff);
        map_pixel(8'd101, 8'd100, 8'd100);
        map_pixel(8'd7, 8'd200, 8'd7);
        map_pixel(8'hff, 8'h00, 8'h00);
        map_pixel(8'h00, 8'hff, 8'h00);
        map_pixel(8'h00, 8'h00, 8'hff);
    endtask

    task automatic test_register_limits();
        // single entry at black gives the largest distance
        set_entries(CFG_W'(1));
        map_pixel(8'hff, 8'hff, 8'hff);
        set_entries(CFG_W'(0));
        map_pixel(8'hff, 8'hff, 8'hff);
        map_pixel(8'h80, 8'h80, 8'h80);
        // two identical entries, lower index wins
        load_entry(8'd1, 8'h00, 8'h00, 8'h00);
        set_entries(CFG_W'(2));
        map_pixel(8'h55, 8'haa, 8'h55);
        set_entries({CFG_W{1'b1}});
        map_pixel(8'h00, 8'h00, 8'h00);
        map_pixel(8'hff, 8'hff, 8'hff);
        set_entries(CFG_W'(DEPTH + 1));
        map_pixel(8'ha5, 8'h5a, 8'hc3);
    endtask

    task automatic test_random_traffic();
        int          sizes [12] = '{3, 1, 16, 256, 8, 0, 5, 300, 2, 64, 12, 511};
        int          items;
        int          span;
        int          pick;
        logic [7:0]  idx;
        for (int p = 0; p < 12; p++) begin
            set_entries(CFG_W'(sizes[p]));
            gaps_on = (p % 3 != 1);
            span = searched_entries(entries_setting);
            items = (span > 32) ? 60 : 130;
            for (int n = 0; n < items; n++) begin
                if ($urandom_range(0, 99) < 15) begin
                    idx = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, span - 1))
                                                      : 8'($urandom);
                    load_entry(idx, 8'($urandom), 8'($urandom), 8'($urandom));
                end else begin
                    pick = $urandom_range(0, 2);
                    idx = 8'($urandom_range(0, span - 1));
                    if (pick == 0)
                        map_pixel(8'($urandom), 8'($urandom), 8'($urandom));
                    else if (pick == 1)
                        map_pixel(near_channel(palette_copy[idx][23:16]),
                                  near_channel(palette_copy[idx][15:8]),
                                  near_channel(palette_copy[idx][7:0]));
                    else
                        map_pixel({8{$urandom_range(0, 1) == 1}},
                                  {8{$urandom_range(0, 1) == 1}},
                                  {8{$urandom_range(0, 1) == 1}});
                end
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_setting();
        test_fill_palette();
        test_extremes_and_ties();
        test_register_limits();
        test_random_traffic();

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("%0d palette loads and %0d pixel maps over %0d register settings",
                 load_count, map_count, setting_count + 1);
        $display("%0d result transactions checked, %0d failures", result_count,
                 mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("[nearest_palette_color_mapper] OK");
        else
            $display("[nearest_palette_color_mapper] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/npcm_pkg.sv
hdl/npcm_ram.sv
hdl/npcm_ctrl.sv
hdl/npcm_datapath.sv
hdl/nearest_palette_color_mapper.sv
bench/nearest_palette_color_mapper_test.sv
